// ===== src/key_state_timeout_release_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the held-key table
// Short forms for the concurrent checks in the top level.
// ---------------------------------------------------------------------------
`ifndef KEY_STATE_TIMEOUT_RELEASE_MACROS_SVH
`define KEY_STATE_TIMEOUT_RELEASE_MACROS_SVH

// same-cycle implication, disabled during reset
`define KSTR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define KSTR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/kstr_pkg.sv =====
// ---------------------------------------------------------------------------
// kstr_pkg
// Shared constants, codes and types of the held-key table.
// ---------------------------------------------------------------------------
package kstr_pkg;

	localparam int HELD_SLOTS_DEF    = 16;
	localparam int KEY_CODE_BITS_DEF = 10;
	localparam int DELAY_W           = 16;
	localparam int TIME_W            = 32;

	localparam logic [DELAY_W-1:0] RELEASE_DELAY_RST = 16'd50;

	// result kinds
	localparam logic [1:0] KIND_KEY  = 2'd0;
	localparam logic [1:0] KIND_SYNC = 2'd1;
	localparam logic [1:0] KIND_FULL = 2'd2;

	// request opcodes
	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_SCAN  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN,
		ST_SYNC
	} kstr_state_t;

	// flags the walk token gathers as it passes the cells
	typedef struct packed {
		logic hit;   // requested key found in a cell already passed
		logic free;  // an empty cell already passed
	} kstr_carry_t;

	// controls broadcast from the sequencer to every cell
	typedef struct packed {
		logic start; // request accepted, token enters the first cell
		logic hold;  // freeze the token, output register is blocked
		logic ins;   // write the new key into the claimed cell
	} kstr_ctrl_t;

endpackage

// ===== src/kstr_cell.sv =====
// ---------------------------------------------------------------------------
// kstr_cell
// One slot of the held-key table plus one stage of the walk token chain.
// ---------------------------------------------------------------------------
module kstr_cell
	import kstr_pkg::*;
#(
	parameter int KEY_CODE_BITS = KEY_CODE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kstr_ctrl_t               ctrl,
	input  logic                     req_scan,
	input  logic                     req_press,
	input  logic [KEY_CODE_BITS-1:0] req_key,
	input  logic [TIME_W-1:0]        req_now,
	input  logic [DELAY_W-1:0]       delay,
	input  logic                     tok_in,
	input  kstr_carry_t              carry_in,
	output logic                     tok_out,
	output kstr_carry_t              carry_out,
	output logic                     emit,
	output logic [KEY_CODE_BITS-1:0] emit_key
);

	logic                     tok_q;
	kstr_carry_t              carry_q;
	logic                     valid_q;
	logic                     claim_q;
	logic [KEY_CODE_BITS-1:0] key_q;
	logic [TIME_W-1:0]        stamp_q;

	logic              act;
	logic              match;
	logic              free_here;
	logic              expired;
	logic [TIME_W-1:0] age;
	logic              commit;

	assign act       = tok_q && !ctrl.hold;
	assign match     = valid_q && (key_q == req_key);
	assign free_here = !valid_q && !carry_q.free;
	assign age       = req_now - stamp_q;
	assign expired   = valid_q && (age >= {{(TIME_W-DELAY_W){1'b0}}, delay});
	assign commit    = ctrl.ins && claim_q;

	assign tok_out        = tok_q;
	assign carry_out.hit  = carry_q.hit || (!req_scan && match);
	assign carry_out.free = carry_q.free || !valid_q;
	assign emit           = tok_q && req_scan && expired;
	assign emit_key       = emit ? key_q : '0;

	// token stage: advance one cell a cycle unless held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			carry_q <= '0;
		end else if (!ctrl.hold) begin
			tok_q   <= tok_in;
			carry_q <= carry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			claim_q <= 1'b0;
		end else begin
			if (ctrl.start)
				claim_q <= 1'b0;
			if (act) begin
				if (req_scan) begin
					if (expired)
						valid_q <= 1'b0;
				end else begin
					if (match && !req_press)
						valid_q <= 1'b0;
					if (free_here && req_press)
						claim_q <= 1'b1;
				end
			end
			if (commit) begin
				valid_q <= 1'b1;
				claim_q <= 1'b0;
			end
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (act && !req_scan && match && req_press)
			stamp_q <= req_now;
		if (commit) begin
			key_q   <= req_key;
			stamp_q <= req_now;
		end
	end

endmodule

// ===== src/key_state_timeout_release.sv =====
// ---------------------------------------------------------------------------
// key_state_timeout_release
// Held-key table with timed automatic release, built as a chain of slot cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one request: a key event
//   (opcode 0: key_code, is_press, now_time) or a release scan (opcode 1).
//   Output channel (out_valid / out_stall) returns zero to HELD_SLOTS+1
//   results, last_of_run marking the final one of each request.
//   cfg_wr_en / cfg_wr_data set release_delay; write only while idle.
// Timing:
//   A request sends a token down the row of HELD_SLOTS cells, one cell per
//   cycle unless held. in_stall rises after the accepting edge and stays
//   high through ST_WALK and ST_FIN, and through ST_SYNC when a key result
//   is followed by a sync: no new request is taken before the last result loads.
//   Scan releases load during the walk, the final scan result in ST_FIN.
// Stall behavior:
//   Results go through a single output register. If it is blocked when a
//   cell wants to emit, the token holds in place until the register frees;
//   the final results wait the same way.
//   The next request is accepted while the last result still waits.
// Reset:
//   arst_n clears all slot valid bits, the token and the sequencer at once;
//   release_delay returns to 50. No clearing pass is needed.
// ---------------------------------------------------------------------------
module key_state_timeout_release
	import kstr_pkg::*;
#(
	parameter int HELD_SLOTS    = HELD_SLOTS_DEF,
	parameter int KEY_CODE_BITS = KEY_CODE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_wr_en,
	input  logic [DELAY_W-1:0]       cfg_wr_data,
	// request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [KEY_CODE_BITS-1:0] key_code,
	input  logic                     is_press,
	input  logic [TIME_W-1:0]        now_time,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               event_kind,
	output logic [KEY_CODE_BITS-1:0] out_key,
	output logic                     key_value,
	output logic                     last_of_run
);

`include "key_state_timeout_release_macros.svh"

	kstr_state_t state_q, state_d;

	logic [DELAY_W-1:0]       delay_q;
	logic                     req_scan_q;
	logic                     req_press_q;
	logic [KEY_CODE_BITS-1:0] req_key_q;
	logic [TIME_W-1:0]        req_now_q;
	logic                     hit_q;
	logic                     free_q;

	logic                     out_valid_q;
	logic [1:0]               out_kind_q;
	logic [KEY_CODE_BITS-1:0] out_key_q;
	logic                     out_val_q;
	logic                     out_last_q;

	kstr_ctrl_t               ctrl;
	logic                     accept;
	logic                     can_load;
	logic                     any_emit;
	logic [KEY_CODE_BITS-1:0] any_key;
	logic                     walk_done;
	logic                     commit_ins;

	logic                     ld;
	logic [1:0]               ld_kind;
	logic [KEY_CODE_BITS-1:0] ld_key;
	logic                     ld_val;
	logic                     ld_last;

	// token chain: entry i feeds cell i, entry HELD_SLOTS leaves the last cell
	logic                     tok_chain   [HELD_SLOTS+1];
	kstr_carry_t              carry_chain [HELD_SLOTS+1];
	logic [HELD_SLOTS-1:0]    tok_vec;
	logic [HELD_SLOTS-1:0]    emit_vec;
	logic [KEY_CODE_BITS-1:0] emit_key_arr [HELD_SLOTS];

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign can_load = !out_valid_q || !out_stall;

	// token waits on an emitting cell while the output register is blocked
	assign ctrl = '{start: accept, hold: any_emit && !can_load, ins: commit_ins};

	assign tok_chain[0]   = accept;
	assign carry_chain[0] = '0;
	assign walk_done      = tok_vec[HELD_SLOTS-1] && !ctrl.hold;

	genvar gi;
	generate
		for (gi = 0; gi < HELD_SLOTS; gi++) begin : g_cell
			kstr_cell #(
				.KEY_CODE_BITS(KEY_CODE_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.req_scan (req_scan_q),
				.req_press(req_press_q),
				.req_key  (req_key_q),
				.req_now  (req_now_q),
				.delay    (delay_q),
				.tok_in   (tok_chain[gi]),
				.carry_in (carry_chain[gi]),
				.tok_out  (tok_chain[gi+1]),
				.carry_out(carry_chain[gi+1]),
				.emit     (emit_vec[gi]),
				.emit_key (emit_key_arr[gi])
			);
			assign tok_vec[gi] = tok_chain[gi+1];
		end
	endgenerate

	// only the cell holding the token can emit, so OR the keys together
	always_comb begin
		any_key = '0;
		for (int i = 0; i < HELD_SLOTS; i++)
			any_key = any_key | emit_key_arr[i];
	end
	assign any_emit = |emit_vec;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_WALK;
			end
			ST_WALK: begin
				if (walk_done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (req_scan_q) begin
					if (can_load)
						state_d = ST_IDLE;
				end else if (req_press_q) begin
					if (hit_q)
						state_d = ST_IDLE;
					else if (can_load)
						state_d = free_q ? ST_SYNC : ST_IDLE;
				end else begin
					if (!hit_q)
						state_d = ST_IDLE;
					else if (can_load)
						state_d = ST_SYNC;
				end
			end
			ST_SYNC: begin
				if (can_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result loads and insert commit
	always_comb begin
		ld         = 1'b0;
		ld_kind    = KIND_SYNC;
		ld_key     = '0;
		ld_val     = 1'b0;
		ld_last    = 1'b0;
		commit_ins = 1'b0;
		case (state_q)
			ST_WALK: begin
				// release of an expired key during a scan
				if (any_emit && can_load) begin
					ld      = 1'b1;
					ld_kind = KIND_KEY;
					ld_key  = any_key;
				end
			end
			ST_FIN: begin
				if (can_load) begin
					if (req_scan_q) begin
						ld      = 1'b1;
						ld_last = 1'b1;
					end else if (req_press_q) begin
						if (!hit_q) begin
							ld      = 1'b1;
							ld_key  = req_key_q;
							ld_val  = 1'b1;
							if (free_q) begin
								ld_kind    = KIND_KEY;
								commit_ins = 1'b1;
							end else begin
								ld_kind = KIND_FULL;
								ld_last = 1'b1;
							end
						end
					end else if (hit_q) begin
						ld      = 1'b1;
						ld_kind = KIND_KEY;
						ld_key  = req_key_q;
					end
				end
			end
			ST_SYNC: begin
				if (can_load) begin
					ld      = 1'b1;
					ld_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			delay_q     <= RELEASE_DELAY_RST;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en)
				delay_q <= cfg_wr_data;
			if (ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			// capture what the token found once it leaves the last cell
			if (state_q == ST_WALK && walk_done) begin
				hit_q  <= carry_chain[HELD_SLOTS].hit;
				free_q <= carry_chain[HELD_SLOTS].free;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_scan_q  <= (opcode == OP_SCAN);
			req_press_q <= is_press;
			req_key_q   <= key_code;
			req_now_q   <= now_time;
		end
		if (ld) begin
			out_kind_q <= ld_kind;
			out_key_q  <= ld_key;
			out_val_q  <= ld_val;
			out_last_q <= ld_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_kind  = out_kind_q;
	assign out_key     = out_key_q;
	assign key_value   = out_val_q;
	assign last_of_run = out_last_q;

	// at most one token in the row
	`KSTR_ASSERT_NOW(a_tok_single, 1'b1, $onehot0(tok_vec), "more than one walk token")
	// no token while the sequencer is idle
	`KSTR_ASSERT_NOW(a_tok_idle, state_q == ST_IDLE, tok_vec == '0, "token while idle")
	// a held token stays where it is
	`KSTR_ASSERT_NEXT(a_tok_hold, ctrl.hold, $stable(tok_vec), "token moved while held")
	// an insert always comes with its key result in the output register
	`KSTR_ASSERT_NEXT(a_ins_result, ctrl.ins, out_valid_q && out_kind_q == KIND_KEY, "bad insert")

endmodule
